@@ src/bkca_pkg.sv @@
// ----------------------------------------------------------------------------
// bkca_pkg
// types, constants and helper functions for the chained-key block cipher
// ----------------------------------------------------------------------------
package bkca_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [CfgIdxW-1:0] RegFirstKeyInit  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSecondKeyInit = CfgIdxW'(1);

  localparam logic [WordW-1:0] Key1Xor   = 16'h5354;
  localparam logic [WordW-1:0] Key2Xor   = 16'h1525;
  localparam logic [WordW-1:0] Key1Add   = 16'h1234;
  localparam logic [WordW-1:0] Key2Add   = 16'h4321;
  localparam logic [WordW-1:0] Key1Reset = 16'h1234;
  localparam logic [WordW-1:0] Key2Reset = 16'h4321;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t plain_w0;
    word_t plain_w1;
    word_t plain_w2;
    word_t plain_w3;
    word_t plain_w4;
    word_t plain_w5;
    word_t plain_w6;
    word_t plain_w7;
    logic  first_block;
  } plain_t;

  typedef struct packed {
    word_t cipher_w0;
    word_t cipher_w1;
    word_t cipher_w2;
    word_t cipher_w3;
    word_t cipher_w4;
    word_t cipher_w5;
    word_t cipher_w6;
    word_t cipher_w7;
    word_t first_key_after;
    word_t second_key_after;
  } cipher_t;

  typedef struct packed {
    word_t first_key_init;
    word_t second_key_init;
  } cfg_t;

  function automatic word_t rot_right1(input word_t v);
    return {v[0], v[WordW-1:1]};
  endfunction

  function automatic word_t rot_left1(input word_t v);
    return {v[WordW-2:0], v[WordW-1]};
  endfunction

endpackage

@@ src/bkca_if.sv @@
// ----------------------------------------------------------------------------
// bkca interfaces
// valid/ready channels for plaintext blocks, cipher results and register writes
// ----------------------------------------------------------------------------
interface bkca_plain_if;
  logic              valid;
  logic              ready;
  bkca_pkg::plain_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bkca_cipher_if;
  logic              valid;
  logic              ready;
  bkca_pkg::cipher_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bkca_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bkca_pkg::CfgIdxW-1:0]     index;
  logic [bkca_pkg::WordW-1:0]       wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ src/bkca_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bkca_cfg_regs
// starting key registers, written through the register channel
// ----------------------------------------------------------------------------
module bkca_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  bkca_cfg_if.sink        cfg_i,
  output bkca_pkg::cfg_t  cfg_o
);

  bkca_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bkca_pkg::RegFirstKeyInit:  cfg_d.first_key_init  = cfg_i.wdata;
        bkca_pkg::RegSecondKeyInit: cfg_d.second_key_init = cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_key_init  <= bkca_pkg::Key1Reset;
      cfg_q.second_key_init <= bkca_pkg::Key2Reset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/bkca_encrypt.sv @@
// ----------------------------------------------------------------------------
// bkca_encrypt
// one block: word sums, key chain and word additions
// ----------------------------------------------------------------------------
module bkca_encrypt (
  input  bkca_pkg::plain_t   plain_i,
  input  bkca_pkg::word_t    key1_i,
  input  bkca_pkg::word_t    key2_i,
  input  bkca_pkg::cfg_t     cfg_i,
  output bkca_pkg::cipher_t  cipher_o
);

  bkca_pkg::word_t k1, k2, k1a, k2a, k1b, k2b, k1c, k2c, k1d, k2d;
  bkca_pkg::word_t b1, b2;

  always_comb begin
    // reload keys on a first block
    k1 = plain_i.first_block ? cfg_i.first_key_init  : key1_i;
    k2 = plain_i.first_block ? cfg_i.second_key_init : key2_i;

    b1 = (plain_i.plain_w0 + plain_i.plain_w1) + (plain_i.plain_w2 + plain_i.plain_w3);
    b2 = (plain_i.plain_w4 + plain_i.plain_w5) + (plain_i.plain_w6 + plain_i.plain_w7);

    k1a = k1 ^ bkca_pkg::Key1Xor;
    k2a = k2 ^ bkca_pkg::Key2Xor;
    k1b = bkca_pkg::rot_right1(k1a + bkca_pkg::Key1Add);
    k2b = bkca_pkg::rot_left1(k2a + bkca_pkg::Key2Add);
    k1c = k1b ^ bkca_pkg::Key1Xor;
    k2c = k2b ^ bkca_pkg::Key2Xor;
    k1d = bkca_pkg::rot_right1(k1c + bkca_pkg::Key1Add);
    k2d = bkca_pkg::rot_left1(k2c + bkca_pkg::Key2Add);

    cipher_o.cipher_w0        = plain_i.plain_w0 + k1;
    cipher_o.cipher_w1        = plain_i.plain_w1 + k2;
    cipher_o.cipher_w2        = plain_i.plain_w2 + k1a;
    cipher_o.cipher_w3        = plain_i.plain_w3 + k2a;
    cipher_o.cipher_w4        = plain_i.plain_w4 + k1b;
    cipher_o.cipher_w5        = plain_i.plain_w5 + k2b;
    cipher_o.cipher_w6        = plain_i.plain_w6 + k1c;
    cipher_o.cipher_w7        = plain_i.plain_w7 + k2c;
    cipher_o.first_key_after  = k1d + b1;
    cipher_o.second_key_after = k2d + b2;
  end

endmodule

@@ src/block_key_chained_add_cipher.sv @@
// An accepted block goes into the input register, then the result register, to cipher_o.
// Throughput: one block per cycle unless cipher_o stalls; the key chain in the
// compute stage (three dependent 16-bit adds with rotates) sets the clock period.
// Output stall holds the result register, then the input register.
// Reset: valids cleared, running keys and starting keys set to 0x1234 and 0x4321.
// ----------------------------------------------------------------------------
// block_key_chained_add_cipher
// two-stage block cipher with running keys chained from block to block
// ----------------------------------------------------------------------------
module block_key_chained_add_cipher (
  input  logic           clk_i,
  input  logic           rst_ni,
  bkca_cfg_if.sink       cfg_i,
  bkca_plain_if.sink     plain_i,
  bkca_cipher_if.source  cipher_o
);

  bkca_pkg::cfg_t    cfg;
  bkca_pkg::plain_t  s1_q;
  logic              s1_valid_q, s1_valid_d;
  bkca_pkg::cipher_t res;
  bkca_pkg::cipher_t out_q;
  logic              out_valid_q;
  bkca_pkg::word_t   key1_q, key2_q;
  logic              s1_adv;
  logic              plain_acc;

  bkca_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bkca_encrypt u_encrypt (
    .plain_i  (s1_q),
    .key1_i   (key1_q),
    .key2_i   (key2_q),
    .cfg_i    (cfg),
    .cipher_o (res)
  );

  assign s1_adv        = !out_valid_q || cipher_o.ready;
  assign plain_i.ready = !s1_valid_q || s1_adv;
  assign plain_acc     = plain_i.valid && plain_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (plain_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (plain_acc) begin
      s1_q <= plain_i.data;
    end
  end

  // running keys and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      key1_q      <= bkca_pkg::Key1Reset;
      key2_q      <= bkca_pkg::Key2Reset;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        key1_q <= res.first_key_after;
        key2_q <= res.second_key_after;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q <= res;
    end
  end

  assign cipher_o.valid = out_valid_q;
  assign cipher_o.data  = out_q;

`ifndef SYNTHESIS
  a_stall_holds_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !cipher_o.ready |=> s1_valid_q)
    else $error("input stage lost under output stall");

  a_key_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_adv && s1_valid_q) |=> $stable(key1_q) && $stable(key2_q))
    else $error("running keys changed without a block");

  a_key_matches_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_valid_q |=> out_q.first_key_after == key1_q &&
                             out_q.second_key_after == key2_q)
    else $error("reported keys differ from running keys");

  a_out_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_valid_q |=> out_valid_q)
    else $error("result register not loaded");
`endif

endmodule

@@ tb/block_key_chained_add_cipher_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_key_chained_add_cipher_test
// drives plaintext blocks and key register writes into the chained-key cipher,
// predicts every cipher block and key pair, and checks them field by field
// under random source and sink idling, with two long sink hold-offs
// ----------------------------------------------------------------------------
module block_key_chained_add_cipher_test;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ReportMax  = 10;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned WordW      = bkca_pkg::WordW;
  localparam int unsigned IdxW       = bkca_pkg::CfgIdxW;
  localparam logic [IdxW-1:0] RegSpare  = IdxW'(2);
  localparam logic [IdxW-1:0] RegTopIdx = {IdxW{1'b1}};

  logic clk_i;
  logic rst_ni;

  bkca_cfg_if    cfg_bus ();
  bkca_plain_if  plain_bus ();
  bkca_cipher_if cipher_bus ();

  block_key_chained_add_cipher uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .plain_i  (plain_bus),
    .cipher_o (cipher_bus)
  );

  bkca_pkg::plain_t  pending_blocks [$];
  bkca_pkg::cipher_t expected_ciphers [$];

  bkca_pkg::word_t start_key1 = bkca_pkg::Key1Reset;
  bkca_pkg::word_t start_key2 = bkca_pkg::Key2Reset;
  bkca_pkg::word_t chain_key1 = bkca_pkg::Key1Reset;
  bkca_pkg::word_t chain_key2 = bkca_pkg::Key2Reset;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic plain_fired = 1'b0;

  int blocks_sent  = 0;
  int key_reloads  = 0;
  int reg_writes   = 0;
  int results_seen = 0;
  int faults       = 0;
  int quiet_cycles = 0;

  int stall_left = 0;
  int holds_done = 0;

  string result_field [10] = '{"cipher_w0", "cipher_w1", "cipher_w2", "cipher_w3",
                               "cipher_w4", "cipher_w5", "cipher_w6", "cipher_w7",
                               "first_key_after", "second_key_after"};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bkca_pkg::cipher_t encrypt_block(input bkca_pkg::plain_t blk);
    bkca_pkg::word_t   k1;
    bkca_pkg::word_t   k2;
    bkca_pkg::word_t   sum_lo;
    bkca_pkg::word_t   sum_hi;
    bkca_pkg::cipher_t res;
    if (blk.first_block) begin
      chain_key1 = start_key1;
      chain_key2 = start_key2;
      key_reloads++;
    end
    k1 = chain_key1;
    k2 = chain_key2;
    sum_lo = blk.plain_w0 + blk.plain_w1 + blk.plain_w2 + blk.plain_w3;
    sum_hi = blk.plain_w4 + blk.plain_w5 + blk.plain_w6 + blk.plain_w7;

    res.cipher_w0 = blk.plain_w0 + k1;
    res.cipher_w1 = blk.plain_w1 + k2;
    k1 = k1 ^ bkca_pkg::Key1Xor;
    k2 = k2 ^ bkca_pkg::Key2Xor;
    res.cipher_w2 = blk.plain_w2 + k1;
    res.cipher_w3 = blk.plain_w3 + k2;
    k1 = k1 + bkca_pkg::Key1Add;
    k2 = k2 + bkca_pkg::Key2Add;
    k1 = {k1[0], k1[WordW-1:1]};
    k2 = {k2[WordW-2:0], k2[WordW-1]};

    res.cipher_w4 = blk.plain_w4 + k1;
    res.cipher_w5 = blk.plain_w5 + k2;
    k1 = k1 ^ bkca_pkg::Key1Xor;
    k2 = k2 ^ bkca_pkg::Key2Xor;
    res.cipher_w6 = blk.plain_w6 + k1;
    res.cipher_w7 = blk.plain_w7 + k2;
    k1 = k1 + bkca_pkg::Key1Add;
    k2 = k2 + bkca_pkg::Key2Add;
    k1 = {k1[0], k1[WordW-1:1]};
    k2 = {k2[WordW-2:0], k2[WordW-1]};

    k1 = k1 + sum_lo;
    k2 = k2 + sum_hi;
    chain_key1 = k1;
    chain_key2 = k2;
    res.first_key_after  = k1;
    res.second_key_after = k2;
    return res;
  endfunction

  task automatic push_pattern(input bkca_pkg::word_t even_w, input bkca_pkg::word_t odd_w,
                              input logic reload);
    bkca_pkg::plain_t blk;
    blk = {even_w, odd_w, even_w, odd_w, even_w, odd_w, even_w, odd_w, reload};
    pending_blocks.push_back(blk);
  endtask

  task automatic queue_random(input int count);
    bkca_pkg::plain_t blk;
    bkca_pkg::word_t  w [8];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(9))
          0: w[i] = '0;
          1: w[i] = '1;
          2: w[i] = bkca_pkg::word_t'($urandom_range(15));
          3: w[i] = {1'b1, {(WordW-1){1'b1}}} - bkca_pkg::word_t'($urandom_range(15));
          default: w[i] = bkca_pkg::word_t'($urandom);
        endcase
      end
      blk = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], $urandom_range(15) == 0};
      pending_blocks.push_back(blk);
    end
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input bkca_pkg::word_t value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.wdata <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_blocks.size() != 0 || expected_ciphers.size() != 0 || plain_bus.valid);
    repeat (4) @(posedge clk_i);
  endtask

  // plaintext source
  always @(negedge clk_i) begin
    if (!(plain_bus.valid && !plain_fired)) begin
      if (pending_blocks.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        plain_bus.valid <= 1'b1;
        plain_bus.data  <= pending_blocks[0];
      end else begin
        plain_bus.valid <= 1'b0;
      end
    end
  end

  // cipher sink, with long hold-offs to back the pipeline up
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      cipher_bus.ready <= 1'b0;
    end else if ((holds_done == 0 && results_seen >= 300) ||
                 (holds_done == 1 && results_seen >= 1100)) begin
      holds_done++;
      stall_left = HoldCycles - 1;
      cipher_bus.ready <= 1'b0;
    end else begin
      cipher_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      plain_fired = plain_bus.valid && plain_bus.ready;
      if (plain_fired) begin
        expected_ciphers.push_back(encrypt_block(plain_bus.data));
        void'(pending_blocks.pop_front());
        blocks_sent++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_bus.valid && cfg_bus.ready) begin
      reg_writes++;
      case (cfg_bus.index)
        bkca_pkg::RegFirstKeyInit:  start_key1 = cfg_bus.wdata;
        bkca_pkg::RegSecondKeyInit: start_key2 = cfg_bus.wdata;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    logic [$bits(bkca_pkg::cipher_t)-1:0] got_flat;
    logic [$bits(bkca_pkg::cipher_t)-1:0] want_flat;
    bkca_pkg::word_t got_w;
    bkca_pkg::word_t want_w;
    if (rst_ni && cipher_bus.valid && cipher_bus.ready) begin
      results_seen++;
      got_flat = cipher_bus.data;
      if (expected_ciphers.size() == 0) begin
        faults++;
        if (faults <= ReportMax)
          $display("unexpected cipher block %h at %0t", got_flat, $realtime);
      end else begin
        want_flat = expected_ciphers.pop_front();
        for (int i = 0; i < 10; i++) begin
          got_w  = got_flat[$bits(bkca_pkg::cipher_t)-1-WordW*i -: WordW];
          want_w = want_flat[$bits(bkca_pkg::cipher_t)-1-WordW*i -: WordW];
          if (got_w !== want_w) begin
            faults++;
            if (faults <= ReportMax)
              $display("result %0d %s: expected %h, got %h", results_seen,
                       result_field[i], want_w, got_w);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((plain_bus.valid && plain_bus.ready) || (cipher_bus.valid && cipher_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("no request accepted for %0d cycles", StallLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    plain_bus.valid  = 1'b0;
    plain_bus.data   = '0;
    cipher_bus.ready = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.wdata    = '0;
    tx_idle_pct      = 14;
    rx_idle_pct      = 49;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // keys straight out of reset, then a reload from the reset start values
    push_pattern(16'h0000, 16'h0000, 1'b0);
    push_pattern(16'hffff, 16'hffff, 1'b0);
    push_pattern(16'h0000, 16'h0000, 1'b1);
    push_pattern(16'h1234, 16'h4321, 1'b0);
    wait_drained();

    // writes to unused indexes must leave the start keys alone
    write_reg(bkca_pkg::RegFirstKeyInit, 16'hffff);
    write_reg(bkca_pkg::RegSecondKeyInit, 16'h0000);
    write_reg(RegSpare, bkca_pkg::word_t'($urandom));
    write_reg(RegTopIdx, bkca_pkg::word_t'($urandom));
    push_pattern(16'h0000, 16'h0000, 1'b1);
    push_pattern(16'hffff, 16'hffff, 1'b0);
    push_pattern(16'hffff, 16'hffff, 1'b1);
    push_pattern(16'haaaa, 16'h5555, 1'b0);
    push_pattern(16'h5555, 16'haaaa, 1'b0);
    push_pattern(16'h8000, 16'h8000, 1'b0);
    push_pattern(16'h0001, 16'h0001, 1'b1);
    push_pattern(16'hffff, 16'h0000, 1'b0);
    push_pattern(16'h0000, 16'hffff, 1'b0);
    push_pattern(16'h7fff, 16'h8000, 1'b1);
    queue_random(520);
    wait_drained();

    write_reg(bkca_pkg::RegFirstKeyInit, bkca_pkg::word_t'($urandom));
    write_reg(bkca_pkg::RegSecondKeyInit, bkca_pkg::word_t'($urandom));
    tx_idle_pct = 49;
    rx_idle_pct = 14;
    queue_random(510);
    wait_drained();

    write_reg(bkca_pkg::RegFirstKeyInit, 16'h0000);
    write_reg(bkca_pkg::RegSecondKeyInit, 16'hffff);
    write_reg(RegSpare, bkca_pkg::word_t'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(510);
    wait_drained();
    repeat (8) @(posedge clk_i);

    faults += expected_ciphers.size();
    $display("encrypted %0d blocks (%0d key reloads) across %0d register writes",
             blocks_sent, key_reloads, reg_writes);
    $display("checked %0d cipher results with %0d sink hold-offs, %0d faults",
             results_seen, holds_done, faults);
    if (faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
